/* hw/rtl/hed_pkg.sv */
// Package with the shared types and codes of the HTML entity decoder.
`timescale 1ns / 1ps

package hed_pkg;

  // Parser mode of the current message.
  typedef enum logic [1:0] {
    MODE_TEXT    = 2'd0,
    MODE_ENTITY  = 2'd1,
    MODE_DISCARD = 2'd2
  } mode_t;

  // Recorded error of the current message.
  typedef enum logic [1:0] {
    ERR_NONE        = 2'd0,
    ERR_INVALID     = 2'd1,
    ERR_UNSUPPORTED = 2'd2
  } err_t;

  // Result kinds.
  localparam logic [2:0] KIND_DATA        = 3'd0;
  localparam logic [2:0] KIND_DONE_OK     = 3'd1;
  localparam logic [2:0] KIND_INVALID     = 3'd2;
  localparam logic [2:0] KIND_UNSUPPORTED = 3'd3;
  localparam logic [2:0] KIND_NO_ENTITY   = 3'd4;

  // Characters with a special meaning to the parser.
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_QUOT  = 8'h22;
  localparam logic [7:0] CH_APOS  = 8'h27;

  // Largest code point and the surrogate range.
  localparam logic [24:0] CODE_MAX   = 25'h10FFFF;
  localparam logic [20:0] SURR_FIRST = 21'h00D800;
  localparam logic [20:0] SURR_LAST  = 21'h00DFFF;

  // Bits of the numeric flags.
  localparam int FLAG_NUMERIC = 0;
  localparam int FLAG_HEX     = 1;
  localparam int FLAG_BAD     = 2;

  // One input request.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  // One result.
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  out_byte;
    logic [15:0] err_offset;
    logic        run_end;
  } out_t;

endpackage

/* hw/rtl/html_entity_decoder_core.sv */
// Top level of the streaming HTML entity decoder with UTF-8 output.
`timescale 1ns / 1ps

// Usage:
// The input channel (in_valid, in_ready, in_data) takes one text byte per
// request, with in_last marking the final byte of a message. The output
// channel (out_valid, out_ready, out_data) gives one result per request:
// data bytes, and one status result after the final byte of a message.
// run_end marks the last result caused by one input byte.
// Each accepted byte is parsed in the cycle of acceptance, and its results
// are loaded into a result buffer; the first result is visible in the next
// cycle. While out_ready is high the buffer drains one result per cycle, so
// a byte with at most one result sustains one byte per cycle. A byte with k
// results (up to four UTF-8 bytes plus the status) holds the input, and the
// next byte is taken in the cycle in which the last of them leaves.
// A byte that gives no result (entity content) still waits while the buffer
// holds results that do not all leave in that cycle.
// When the receiver stalls, the buffered result holds and in_ready drops
// once the buffer cannot be emptied in the same cycle.
// Reset (rst, synchronous) returns the parser to plain text mode, clears the
// byte position and empties the result buffer.
module html_entity_decoder_core #(
  parameter int MAX_ENTITY_SPAN = 12,
  parameter int POSITION_BITS   = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  hed_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output hed_pkg::out_t  out_data
);

  localparam int LW = $clog2(MAX_ENTITY_SPAN);
  localparam int PW = POSITION_BITS;
  localparam logic [LW-1:0] LEN_LIMIT = LW'(MAX_ENTITY_SPAN - 1);
  localparam logic [PW-1:0] POS_MAX   = {PW{1'b1}};

  // Message state.
  hed_pkg::mode_t  parse_mode, parse_mode_next;
  logic [LW-1:0]   entity_length, entity_length_next;
  logic [7:0]      name_chars [4];
  logic [7:0]      name_chars_next [4];
  logic [20:0]     code_acc, code_acc_next;
  logic [2:0]      num_flags, num_flags_next;
  logic            any_decoded, any_decoded_next;
  hed_pkg::err_t   pending_error, pending_error_next;
  logic [PW-1:0]   byte_position, byte_position_next;
  logic [PW-1:0]   entity_start, entity_start_next;

  // Result buffer.
  logic            buf_valid;
  logic [7:0]      buf_data [4];
  logic [2:0]      buf_ndata;
  logic            buf_status;
  logic [2:0]      buf_kind;
  logic [15:0]     buf_offset;
  logic [2:0]      buf_idx;

  // Results of the byte being accepted.
  logic [7:0]      res_data [4];
  logic [2:0]      res_ndata;
  logic            res_status;
  logic [2:0]      res_kind;
  logic [15:0]     res_offset;

  logic            in_fire;
  logic            out_fire;
  logic            buf_at_last;
  logic [3:0]      buf_total;

  // Saturate a position to the 16-bit offset field.
  function automatic logic [15:0] sat_offset(input logic [PW-1:0] p);
    logic [PW+15:0] ext;
    ext = {16'd0, p};
    sat_offset = (ext > (PW + 16)'(16'hFFFF)) ? 16'hFFFF : ext[15:0];
  endfunction

  // Handshake: a new byte enters when the buffer is empty or empties now.
  assign buf_total   = {1'b0, buf_ndata} + {3'd0, buf_status};
  assign buf_at_last = ({1'b0, buf_idx} + 4'd1) == buf_total;
  assign out_valid   = buf_valid;
  assign out_fire    = buf_valid && out_ready;
  assign in_ready    = !buf_valid || (out_fire && buf_at_last);
  assign in_fire     = in_valid && in_ready;

  // Parse one byte: next message state and the results it causes.
  always_comb begin
    logic [7:0]      b;
    logic [LW-1:0]   p;
    logic            hex;
    logic            is_dec;
    logic            is_let;
    logic [3:0]      digit;
    logic [24:0]     v;
    logic [20:0]     c;
    logic            is_amp;
    logic            is_lt;
    logic            is_gt;
    logic            is_quot;
    logic            is_apos;
    logic [LW-1:0]   prefix;

    b      = in_data.in_byte;
    p      = entity_length;
    hex    = num_flags[hed_pkg::FLAG_HEX];
    is_dec = (b >= "0") && (b <= "9");
    is_let = hex && (((b >= "a") && (b <= "f")) || ((b >= "A") && (b <= "F")));
    digit  = is_dec ? b[3:0] : (b[3:0] + 4'd9);
    v      = hex ? ({code_acc, 4'd0} + {21'd0, digit})
                 : ({1'b0, code_acc, 3'd0} + {3'd0, code_acc, 1'b0} + {21'd0, digit});
    c      = code_acc;
    is_amp = (p == LW'(3)) && (name_chars[0] == "a") && (name_chars[1] == "m") &&
             (name_chars[2] == "p");
    is_lt  = (p == LW'(2)) && (name_chars[0] == "l") && (name_chars[1] == "t");
    is_gt  = (p == LW'(2)) && (name_chars[0] == "g") && (name_chars[1] == "t");
    is_quot = (p == LW'(4)) && (name_chars[0] == "q") && (name_chars[1] == "u") &&
              (name_chars[2] == "o") && (name_chars[3] == "t");
    is_apos = (p == LW'(4)) && (name_chars[0] == "a") && (name_chars[1] == "p") &&
              (name_chars[2] == "o") && (name_chars[3] == "s");
    prefix = hex ? LW'(2) : LW'(1);

    parse_mode_next    = parse_mode;
    entity_length_next = entity_length;
    for (int i = 0; i < 4; i++) begin
      name_chars_next[i] = name_chars[i];
      res_data[i]        = 8'd0;
    end
    code_acc_next      = code_acc;
    num_flags_next     = num_flags;
    any_decoded_next   = any_decoded;
    pending_error_next = pending_error;
    entity_start_next  = entity_start;
    byte_position_next = (byte_position < POS_MAX) ? (byte_position + PW'(1))
                                                   : byte_position;
    res_ndata  = 3'd0;
    res_status = 1'b0;
    res_kind   = hed_pkg::KIND_DONE_OK;
    res_offset = 16'd0;

    case (parse_mode)
      hed_pkg::MODE_TEXT: begin
        if (b == hed_pkg::CH_AMP) begin
          parse_mode_next    = hed_pkg::MODE_ENTITY;
          entity_start_next  = byte_position;
          entity_length_next = '0;
          for (int i = 0; i < 4; i++) begin
            name_chars_next[i] = 8'd0;
          end
          code_acc_next  = 21'd0;
          num_flags_next = 3'd0;
        end else begin
          res_data[0] = b;
          res_ndata   = 3'd1;
        end
      end
      hed_pkg::MODE_ENTITY: begin
        if (b == hed_pkg::CH_SEMI) begin
          // Close the entity: named forms first, then the numeric form.
          parse_mode_next = hed_pkg::MODE_TEXT;
          if (is_amp || is_lt || is_gt || is_quot || is_apos) begin
            res_data[0] = is_amp ? hed_pkg::CH_AMP :
                          is_lt  ? hed_pkg::CH_LT  :
                          is_gt  ? hed_pkg::CH_GT  :
                          is_quot ? hed_pkg::CH_QUOT : hed_pkg::CH_APOS;
            res_ndata        = 3'd1;
            any_decoded_next = 1'b1;
          end else if ((p != '0) && num_flags[hed_pkg::FLAG_NUMERIC]) begin
            if ((p <= prefix) || num_flags[hed_pkg::FLAG_BAD] || (c == 21'd0) ||
                ((c >= hed_pkg::SURR_FIRST) && (c <= hed_pkg::SURR_LAST))) begin
              pending_error_next = hed_pkg::ERR_INVALID;
              parse_mode_next    = hed_pkg::MODE_DISCARD;
            end else begin
              any_decoded_next = 1'b1;
              // UTF-8 encoding of the code point.
              if (c <= 21'h7F) begin
                res_data[0] = c[7:0];
                res_ndata   = 3'd1;
              end else if (c <= 21'h7FF) begin
                res_data[0] = {3'b110, c[10:6]};
                res_data[1] = {2'b10, c[5:0]};
                res_ndata   = 3'd2;
              end else if (c <= 21'hFFFF) begin
                res_data[0] = {4'b1110, c[15:12]};
                res_data[1] = {2'b10, c[11:6]};
                res_data[2] = {2'b10, c[5:0]};
                res_ndata   = 3'd3;
              end else begin
                res_data[0] = {5'b11110, c[20:18]};
                res_data[1] = {2'b10, c[17:12]};
                res_data[2] = {2'b10, c[11:6]};
                res_data[3] = {2'b10, c[5:0]};
                res_ndata   = 3'd4;
              end
            end
          end else begin
            pending_error_next = hed_pkg::ERR_UNSUPPORTED;
            parse_mode_next    = hed_pkg::MODE_DISCARD;
          end
        end else if (entity_length >= LEN_LIMIT) begin
          pending_error_next = hed_pkg::ERR_INVALID;
          parse_mode_next    = hed_pkg::MODE_DISCARD;
        end else begin
          // Collect one content byte and advance the numeric accumulator.
          if (p < LW'(4)) begin
            name_chars_next[p[1:0]] = b;
          end
          if (p == '0) begin
            if (b == hed_pkg::CH_HASH) begin
              num_flags_next = 3'b001;
            end
          end else if (num_flags[hed_pkg::FLAG_NUMERIC]) begin
            if ((p == LW'(1)) && ((b == "x") || (b == "X"))) begin
              num_flags_next[hed_pkg::FLAG_HEX] = 1'b1;
            end else if (!num_flags[hed_pkg::FLAG_BAD]) begin
              if (!(is_dec || is_let)) begin
                num_flags_next[hed_pkg::FLAG_BAD] = 1'b1;
              end else if (v > hed_pkg::CODE_MAX) begin
                num_flags_next[hed_pkg::FLAG_BAD] = 1'b1;
              end else begin
                code_acc_next = v[20:0];
              end
            end
          end
          entity_length_next = p + LW'(1);
        end
      end
      default: begin
      end
    endcase

    // Final byte: close the message with a status and reset its state.
    if (in_data.in_last) begin
      res_status = 1'b1;
      if (parse_mode_next == hed_pkg::MODE_ENTITY) begin
        pending_error_next = hed_pkg::ERR_INVALID;
      end
      if (pending_error_next != hed_pkg::ERR_NONE) begin
        res_kind   = (pending_error_next == hed_pkg::ERR_INVALID) ?
                     hed_pkg::KIND_INVALID : hed_pkg::KIND_UNSUPPORTED;
        res_offset = sat_offset(entity_start_next);
      end else if (!any_decoded_next) begin
        res_kind = hed_pkg::KIND_NO_ENTITY;
      end else begin
        res_kind = hed_pkg::KIND_DONE_OK;
      end
      parse_mode_next    = hed_pkg::MODE_TEXT;
      entity_length_next = '0;
      for (int i = 0; i < 4; i++) begin
        name_chars_next[i] = 8'd0;
      end
      code_acc_next      = 21'd0;
      num_flags_next     = 3'd0;
      any_decoded_next   = 1'b0;
      pending_error_next = hed_pkg::ERR_NONE;
      byte_position_next = '0;
      entity_start_next  = '0;
    end
  end

  // Message state registers, updated on each accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode    <= hed_pkg::MODE_TEXT;
      entity_length <= '0;
      for (int i = 0; i < 4; i++) begin
        name_chars[i] <= 8'd0;
      end
      code_acc      <= 21'd0;
      num_flags     <= 3'd0;
      any_decoded   <= 1'b0;
      pending_error <= hed_pkg::ERR_NONE;
      byte_position <= '0;
      entity_start  <= '0;
    end else if (in_fire) begin
      parse_mode    <= parse_mode_next;
      entity_length <= entity_length_next;
      for (int i = 0; i < 4; i++) begin
        name_chars[i] <= name_chars_next[i];
      end
      code_acc      <= code_acc_next;
      num_flags     <= num_flags_next;
      any_decoded   <= any_decoded_next;
      pending_error <= pending_error_next;
      byte_position <= byte_position_next;
      entity_start  <= entity_start_next;
    end
  end

  // Result buffer: load on a request with results, drain one per ready cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      buf_idx   <= 3'd0;
    end else if (in_fire && ((res_ndata != 3'd0) || res_status)) begin
      buf_valid <= 1'b1;
      buf_idx   <= 3'd0;
    end else if (out_fire) begin
      if (buf_at_last) begin
        buf_valid <= 1'b0;
      end
      buf_idx <= buf_idx + 3'd1;
    end
  end

  // Result buffer payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < 4; i++) begin
        buf_data[i] <= res_data[i];
      end
      buf_ndata  <= res_ndata;
      buf_status <= res_status;
      buf_kind   <= res_kind;
      buf_offset <= res_offset;
    end
  end

  // Output selection: data bytes first, then the status.
  always_comb begin
    out_data = '0;
    if (buf_idx < buf_ndata) begin
      out_data.kind     = hed_pkg::KIND_DATA;
      out_data.out_byte = buf_data[buf_idx[1:0]];
    end else begin
      out_data.kind       = buf_kind;
      out_data.err_offset = buf_offset;
    end
    out_data.run_end = buf_at_last;
  end

endmodule
